// ===== hdl/rle_pkg.sv =====
// Shared types, constants and the interpolation function of the rate/level envelope.
package rle_pkg;

  localparam int MAX_SEG    = 8;
  localparam int SEG_W      = $clog2(MAX_SEG);
  localparam int CNT_W      = SEG_W + 1;
  localparam int LEVEL_W    = 16;
  localparam int PHASE_FRAC = 24;
  localparam int PHASE_W    = PHASE_FRAC + 1;
  localparam int PROD_W     = (LEVEL_W + 1) + (PHASE_W + 1);
  localparam int QUOT_W     = PROD_W - PHASE_FRAC;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_KEY_ON  = 2'd1,
    OP_KEY_OFF = 2'd2,
    OP_WRITE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_RUN  = 3'd1,
    MODE_SUS  = 3'd2,
    MODE_REL  = 3'd3,
    MODE_DONE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    CFG_SEG_COUNT = 2'd0,
    CFG_SUSTAIN   = 2'd1,
    CFG_AMP       = 2'd2,
    CFG_IGN_REL   = 2'd3
  } cfg_idx_t;

  // Decoded configuration handed to the step logic
  typedef struct packed {
    logic [SEG_W-1:0] last;
    logic             sus_on;
    logic [SEG_W-1:0] sus_idx;
    logic             amp;
    logic             ign_rel;
  } cfg_t;

  typedef struct packed {
    op_t                      op;
    logic [SEG_W-1:0]         idx;
    logic signed [LEVEL_W-1:0] level;
    logic [PHASE_W-1:0]       inc;
  } in_item_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] value;
    mode_t                     mode;
    logic [SEG_W-1:0]          segment;
    logic                      voice_done;
  } out_item_t;

  typedef struct packed {
    logic                      en;
    logic [SEG_W-1:0]          addr;
    logic signed [LEVEL_W-1:0] level;
    logic [PHASE_W-1:0]        inc;
  } seg_wr_t;

  typedef struct packed {
    logic             en;
    logic [SEG_W-1:0] addr;
  } seg_rd_t;

  // Last segment in use: zero count acts as one, large counts clamp to the table
  function automatic logic [SEG_W-1:0] last_seg(input logic [CNT_W-1:0] cnt);
    logic [SEG_W-1:0] res;
    if (cnt == '0) begin
      res = '0;
    end else if (cnt > CNT_W'(MAX_SEG)) begin
      res = SEG_W'(MAX_SEG - 1);
    end else begin
      res = SEG_W'(cnt - CNT_W'(1));
    end
    return res;
  endfunction

  // start + floor((diff * phase + half) / one), rounding half upwards
  function automatic logic signed [LEVEL_W-1:0] interp(
    input logic signed [LEVEL_W-1:0] s,
    input logic signed [LEVEL_W-1:0] t,
    input logic [PHASE_W-1:0]        ph
  );
    logic signed [LEVEL_W:0]   diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [QUOT_W-1:0]  q;
    logic signed [QUOT_W-1:0]  sum;
    diff = LEVEL_W'(1) == 0 ? '0 : ($signed({t[LEVEL_W-1], t}) - $signed({s[LEVEL_W-1], s}));
    prod = diff * $signed({1'b0, ph});
    rnd  = prod + (PROD_W'(1) <<< (PHASE_FRAC - 1));
    q    = rnd[PROD_W-1:PHASE_FRAC];
    sum  = QUOT_W'(s) + q;
    return sum[LEVEL_W-1:0];
  endfunction

endpackage

// ===== hdl/rle_seg_mem.sv =====
// Segment table RAM: level and increment per segment, one step read port and one done-level port.
module rle_seg_mem import rle_pkg::*; (
  input  logic                      clk,
  input  seg_wr_t                   wr,
  input  seg_rd_t                   rd,
  input  logic [SEG_W-1:0]          last_addr,
  output logic signed [LEVEL_W-1:0] rd_level,
  output logic [PHASE_W-1:0]        rd_inc,
  output logic signed [LEVEL_W-1:0] last_level
);

  logic signed [LEVEL_W-1:0] lvl_mem [MAX_SEG];
  logic [PHASE_W-1:0]        inc_mem [MAX_SEG];

  logic signed [LEVEL_W-1:0] rd_level_r;
  logic [PHASE_W-1:0]        rd_inc_r;
  logic signed [LEVEL_W-1:0] last_level_r;

  // Write an entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      lvl_mem[wr.addr] <= wr.level;
      inc_mem[wr.addr] <= wr.inc;
    end
  end

  // Fetch the entry of a starting segment; hold it until the next fetch
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_level_r <= lvl_mem[rd.addr];
      rd_inc_r   <= inc_mem[rd.addr];
    end
  end

  // Track the level of the last segment, forwarding a write to the same entry
  always_ff @(posedge clk) begin
    if (wr.en && wr.addr == last_addr) begin
      last_level_r <= wr.level;
    end else begin
      last_level_r <= lvl_mem[last_addr];
    end
  end

  assign rd_level   = rd_level_r;
  assign rd_inc     = rd_inc_r;
  assign last_level = last_level_r;

endmodule

// ===== hdl/rle_step.sv =====
// Envelope state registers, segment sequencing and linear interpolation for one transaction.
module rle_step import rle_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  in_item_t                  item,
  input  cfg_t                      cfg,
  input  logic signed [LEVEL_W-1:0] rd_level,
  input  logic [PHASE_W-1:0]        rd_inc,
  input  logic signed [LEVEL_W-1:0] last_level,
  output seg_wr_t                   wr,
  output seg_rd_t                   rd,
  output out_item_t                 res
);

  mode_t                     mode_r, mode_nxt;
  logic [SEG_W-1:0]          seg_r, seg_nxt;
  logic signed [LEVEL_W-1:0] start_r, start_nxt;
  logic signed [LEVEL_W-1:0] target_r, target_nxt;
  logic signed [LEVEL_W-1:0] cur_r, cur_nxt;
  logic [PHASE_W-1:0]        phase_r, phase_nxt;
  logic [PHASE_W-1:0]        step_r, step_nxt;
  logic                      pend_r, pend_nxt;

  logic signed [LEVEL_W-1:0] tgt_e;
  logic [PHASE_W-1:0]        step_e;
  logic [PHASE_W-1:0]        ph_e;
  logic [PHASE_W:0]          ph_sum;
  logic                      fin;
  logic [PHASE_W-1:0]        ph_adv;
  logic signed [LEVEL_W-1:0] cur_adv;
  logic [SEG_W-1:0]          seg_inc;
  logic [CNT_W-1:0]          sus_next;
  logic                      done_pulse;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      seg_r    <= '0;
      start_r  <= '0;
      target_r <= '0;
      cur_r    <= '0;
      phase_r  <= '0;
      step_r   <= '0;
      pend_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      seg_r    <= seg_nxt;
      start_r  <= start_nxt;
      target_r <= target_nxt;
      cur_r    <= cur_nxt;
      phase_r  <= phase_nxt;
      step_r   <= step_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // Take target and step from the RAM in the cycle after a segment starts
  assign tgt_e  = pend_r ? rd_level : target_r;
  assign step_e = pend_r ? rd_inc : step_r;
  assign ph_e   = pend_r ? ((rd_inc == '0) ? PHASE_ONE : '0) : phase_r;

  // Advance the phase, saturate at one, interpolate
  assign ph_sum  = {1'b0, ph_e} + {1'b0, step_e};
  assign fin     = ph_sum >= {1'b0, PHASE_ONE};
  assign ph_adv  = fin ? PHASE_ONE : ph_sum[PHASE_W-1:0];
  assign cur_adv = interp(start_r, tgt_e, ph_adv);

  assign seg_inc  = seg_r + SEG_W'(1);
  assign sus_next = {1'b0, cfg.sus_idx} + CNT_W'(1);

  // Next state per transaction
  always_comb begin
    mode_nxt   = mode_r;
    seg_nxt    = seg_r;
    start_nxt  = start_r;
    target_nxt = tgt_e;
    step_nxt   = step_e;
    phase_nxt  = ph_e;
    cur_nxt    = cur_r;
    pend_nxt   = 1'b0;
    done_pulse = 1'b0;
    rd.en      = 1'b0;
    rd.addr    = seg_inc;
    wr.en      = 1'b0;
    wr.addr    = item.idx;
    wr.level   = item.level;
    wr.inc     = item.inc;
    if (fire) begin
      case (item.op)
        OP_WRITE: begin
          wr.en = 1'b1;
        end
        OP_KEY_ON: begin
          cur_nxt   = '0;
          start_nxt = '0;
          seg_nxt   = '0;
          rd.en     = 1'b1;
          rd.addr   = '0;
          pend_nxt  = 1'b1;
          mode_nxt  = MODE_RUN;
        end
        OP_KEY_OFF: begin
          if (mode_r == MODE_RUN || mode_r == MODE_SUS || mode_r == MODE_REL) begin
            mode_nxt = MODE_REL;
            if (!cfg.ign_rel && cfg.sus_on) begin
              if (sus_next > {1'b0, cfg.last}) begin
                mode_nxt = MODE_DONE;
              end else begin
                seg_nxt   = sus_next[SEG_W-1:0];
                start_nxt = cur_r;
                rd.en     = 1'b1;
                rd.addr   = sus_next[SEG_W-1:0];
                pend_nxt  = 1'b1;
              end
            end
          end
        end
        OP_TICK: begin
          case (mode_r)
            MODE_RUN, MODE_REL: begin
              phase_nxt = ph_adv;
              cur_nxt   = cur_adv;
              if (fin) begin
                if (mode_r == MODE_RUN && cfg.sus_on && seg_r == cfg.sus_idx) begin
                  mode_nxt = MODE_SUS;
                end else if (mode_r == MODE_RUN && !(cfg.sus_on && seg_r < cfg.sus_idx)) begin
                  mode_nxt = MODE_REL;
                end else if (seg_r >= cfg.last) begin
                  mode_nxt = MODE_DONE;
                end else begin
                  seg_nxt   = seg_inc;
                  start_nxt = cur_adv;
                  rd.en     = 1'b1;
                  rd.addr   = seg_inc;
                  pend_nxt  = 1'b1;
                end
              end
            end
            MODE_DONE: begin
              if (cfg.amp) begin
                cur_nxt    = '0;
                done_pulse = 1'b1;
              end else begin
                cur_nxt = last_level;
              end
              mode_nxt = MODE_IDLE;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    res.value      = cur_nxt;
    res.mode       = mode_nxt;
    res.segment    = seg_nxt;
    res.voice_done = done_pulse;
  end

endmodule

// ===== hdl/rle_out_stage.sv =====
// Output register that holds one result while the receiver stalls.
module rle_out_stage import rle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t item,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_item,
  output logic      in_ready
);

  logic      valid_r;
  out_item_t item_r;

  // Valid flag: set on load, clear once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== hdl/rate_level_envelope.sv =====
// Top level of the multi-segment rate/level envelope generator.
// Usage:
//   in_*  : one transaction per command; in_tuser carries the op (tick, key on, key off,
//           write segment entry), in_tdata the segment entry fields for a write.
//   out_* : exactly one result transaction per accepted command: value, mode, segment
//           and the voice_done pulse, all as they stand after that command.
//   cfg_* : register writes (segment count, sustain segment, amplitude mode, ignore
//           release), taken at any edge with cfg_we high; the user is to write them only while
//           no command is in flight, which the block itself does not enforce.
// A result is offered in the cycle after its command is accepted; one command per cycle
// while in_tready is high. The segment table sits in a small RAM with a registered read; a
// starting segment fetches its entry in the same cycle and the next takes it from the read register.
// Reset: mode idle, value zero, registers at their defaults; the segment table is not
// cleared and must be written before a segment that uses it is started.
// Stall: the output register holds a result while out_tready is low; a new command is
// still accepted in the cycle the held result is taken.
module rate_level_envelope import rle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // seg_index[2:0], seg_level[18:3], seg_increment[43:19]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // value[15:0], mode[18:16], segment[21:19], voice_done[22]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [3:0]  cfg_wdata
);

  logic [CNT_W-1:0] seg_count_r, seg_count_nxt;
  logic [3:0]       sustain_r, sustain_nxt;
  logic             amp_r, amp_nxt;
  logic             ign_rel_r, ign_rel_nxt;

  cfg_t                      cfg;
  logic [SEG_W-1:0]          last_nxt;
  logic                      fire;
  in_item_t                  item;
  out_item_t                 res;
  out_item_t                 out_item;
  seg_wr_t                   wr;
  seg_rd_t                   rd;
  logic signed [LEVEL_W-1:0] rd_level;
  logic [PHASE_W-1:0]        rd_inc;
  logic signed [LEVEL_W-1:0] last_level;

  // Configuration registers
  always_comb begin
    seg_count_nxt = seg_count_r;
    sustain_nxt   = sustain_r;
    amp_nxt       = amp_r;
    ign_rel_nxt   = ign_rel_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_SEG_COUNT: seg_count_nxt = cfg_wdata[CNT_W-1:0];
        CFG_SUSTAIN:   sustain_nxt   = cfg_wdata;
        CFG_AMP:       amp_nxt       = cfg_wdata[0];
        CFG_IGN_REL:   ign_rel_nxt   = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= CNT_W'(1);
      sustain_r   <= 4'hF;
      amp_r       <= 1'b0;
      ign_rel_r   <= 1'b0;
    end else begin
      seg_count_r <= seg_count_nxt;
      sustain_r   <= sustain_nxt;
      amp_r       <= amp_nxt;
      ign_rel_r   <= ign_rel_nxt;
    end
  end

  // Decode the configuration; the RAM tracks the next last segment
  assign last_nxt    = last_seg(seg_count_nxt);
  assign cfg.last    = last_seg(seg_count_r);
  assign cfg.sus_on  = !sustain_r[3];
  assign cfg.sus_idx = sustain_r[SEG_W-1:0];
  assign cfg.amp     = amp_r;
  assign cfg.ign_rel = ign_rel_r;

  // Unpack the command
  assign fire       = in_tvalid && in_tready;
  assign item.op    = op_t'(in_tuser);
  assign item.idx   = in_tdata[2:0];
  assign item.level = $signed(in_tdata[18:3]);
  assign item.inc   = in_tdata[43:19];

  rle_seg_mem u_mem (
    .clk        (clk),
    .wr         (wr),
    .rd         (rd),
    .last_addr  (last_nxt),
    .rd_level   (rd_level),
    .rd_inc     (rd_inc),
    .last_level (last_level)
  );

  rle_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (item),
    .cfg        (cfg),
    .rd_level   (rd_level),
    .rd_inc     (rd_inc),
    .last_level (last_level),
    .wr         (wr),
    .rd         (rd),
    .res        (res)
  );

  rle_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .item      (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_item  (out_item),
    .in_ready  (in_tready)
  );

  // Pack the result
  assign out_tdata = {1'b0, out_item.voice_done, out_item.segment, out_item.mode,
                      out_item.value};

  // Every accepted transaction yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("accepted transaction without a result");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // voice_done only with zero value and idle mode
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[22]) |-> (out_tdata[15:0] == '0 && out_tdata[18:16] == MODE_IDLE))
    else $error("voice_done with non-zero value or active mode");

endmodule
